[rtl/ffdf_pkg.sv]
// Shared types, constants and helper functions for the %f decimal formatter.
`timescale 1ns / 1ps
package ffdf_pkg;

  localparam int unsigned MAX_PRECISION = 19;
  localparam int unsigned MAX_WIDTH     = 64;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  localparam logic [63:0] SAT_INT = 64'h7FFF_FFFF_FFFF_FFFF;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_PREC  = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_LJUST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_SHF,
    ST_FIX,
    ST_BCDI,
    ST_BCDF,
    ST_EMIT
  } state_t;

  // Powers of ten, 10^0 .. 10^19
  function automatic logic [63:0] pow10(input logic [4:0] p);
    logic [63:0] r;
    case (p)
      5'd0:  r = 64'd1;
      5'd1:  r = 64'd10;
      5'd2:  r = 64'd100;
      5'd3:  r = 64'd1000;
      5'd4:  r = 64'd10000;
      5'd5:  r = 64'd100000;
      5'd6:  r = 64'd1000000;
      5'd7:  r = 64'd10000000;
      5'd8:  r = 64'd100000000;
      5'd9:  r = 64'd1000000000;
      5'd10: r = 64'd10000000000;
      5'd11: r = 64'd100000000000;
      5'd12: r = 64'd1000000000000;
      5'd13: r = 64'd10000000000000;
      5'd14: r = 64'd100000000000000;
      5'd15: r = 64'd1000000000000000;
      5'd16: r = 64'd10000000000000000;
      5'd17: r = 64'd100000000000000000;
      5'd18: r = 64'd1000000000000000000;
      5'd19: r = 64'd10000000000000000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

  // One double-dabble step: adjust each BCD digit, then shift in one bit
  function automatic logic [79:0] dd_step(input logic [79:0] bcd, input logic bit_in);
    logic [79:0] adj;
    adj = bcd;
    for (int d = 0; d < 20; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end
    end
    return {adj[78:0], bit_in};
  endfunction

endpackage

[rtl/float_fixed_decimal_formatter.sv]
// Top level: binary64 to %f text, one ASCII character per output beat.
//
// Usage: an input beat (in_valid high, in_stall low) carries one binary64
// pattern. The block raises in_stall until that value's whole text has been
// handed to the output register, then takes the next value. Each output beat
// carries one character; out_last_char marks the final one.
// Processing order: the input is decoded and registered when taken, then
// the fraction is multiplied by ten once per precision digit (effective
// precision 0..19), passes the ST_RND, ST_SHF and ST_FIX rounding states,
// then runs double-dabble through one shared BCD step unit (integer part,
// then fraction). Characters then leave at one per cycle unless the receiver stalls.
// Huge, infinity, NaN, integral and very small values skip the fraction steps.
// When the receiver stalls, the current character holds and the emit
// counter waits. Reset returns to idle with precision 6, field width 0 and
// right justification, and drops any pending output.
// Registers (APB): 0 precision_digits, 4 field_width, 8 left_justify.
`timescale 1ns / 1ps
module float_fixed_decimal_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_text_char,
  output logic        out_last_char,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [4:0] prec_r;
  logic [6:0] fwidth_r;
  logic       ljust_r;

  ffdf_pkg::state_t state_r, state_nxt;

  logic [63:0]  ip_r;
  logic [63:0]  fr_r;
  logic [127:0] prod_r;
  logic [6:0]   k_r;
  logic         neg_r;
  logic [79:0]  ibcd_r;
  logic [79:0]  fbcd_r;
  logic [5:0]   cnt_r;
  logic [4:0]   mcnt_r;
  logic [6:0]   i_r;

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  // Saturated settings
  logic [4:0] p_eff;
  logic [6:0] w_eff;
  assign p_eff = (prec_r > 5'(ffdf_pkg::MAX_PRECISION)) ? 5'(ffdf_pkg::MAX_PRECISION) : prec_r;
  assign w_eff = (fwidth_r > 7'(ffdf_pkg::MAX_WIDTH)) ? 7'(ffdf_pkg::MAX_WIDTH) : fwidth_r;

  // APB port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      ffdf_pkg::REG_PREC:  prdata = {27'd0, prec_r};
      ffdf_pkg::REG_WIDTH: prdata = {25'd0, fwidth_r};
      ffdf_pkg::REG_LJUST: prdata = {31'd0, ljust_r};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r   <= 5'd6;
      fwidth_r <= 7'd0;
      ljust_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ffdf_pkg::REG_PREC:  prec_r   <= pwdata[4:0];
        ffdf_pkg::REG_WIDTH: fwidth_r <= pwdata[6:0];
        ffdf_pkg::REG_LJUST: ljust_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Input decode
  logic [10:0]  ex;
  logic [10:0]  exe;
  logic [52:0]  mant;
  logic         dec_sat;
  logic         dec_int;
  logic [10:0]  dec_k;
  logic [63:0]  dec_ip;
  logic [52:0]  dec_fm;
  logic         dec_frac;

  always_comb begin
    ex   = in_value_bits[62:52];
    exe  = (ex == 11'd0) ? 11'd1 : ex;
    mant = {(ex != 11'd0), in_value_bits[51:0]};
    dec_sat = (ex == 11'h7FF) || (exe >= 11'd1086);
    dec_int = (exe >= 11'd1075);
    dec_k   = 11'd1075 - exe;
    dec_fm  = mant;
    dec_ip  = 64'd0;
    if (dec_sat) begin
      dec_ip = ffdf_pkg::SAT_INT;
    end else if (dec_int) begin
      dec_ip = {11'd0, mant} << (exe - 11'd1075);
    end else if (dec_k < 11'd64) begin
      dec_ip = {11'd0, mant} >> dec_k[5:0];
      dec_fm = mant & ~(53'h1F_FFFF_FFFF_FFFF << dec_k[5:0]);
    end
    dec_frac = !dec_sat && !dec_int && (dec_k < 11'd118);
  end

  // Text geometry
  logic [4:0] nd;
  logic [6:0] txt_n;
  logic [6:0] total;
  logic [6:0] pad;

  always_comb begin
    nd = 5'd1;
    for (int d = 1; d < 20; d++) begin
      if (ibcd_r[d*4 +: 4] != 4'd0) begin
        nd = 5'(d + 1);
      end
    end
    txt_n = 7'(neg_r) + 7'(nd) + ((p_eff != 5'd0) ? 7'(p_eff) + 7'd1 : 7'd0);
    total = (w_eff > txt_n) ? w_eff : txt_n;
    pad   = total - txt_n;
  end

  // Character select for position i_r
  logic [6:0] pos;
  logic [6:0] pos2;
  logic       in_txt;
  logic [4:0] didx;
  logic [7:0] cur_char;

  always_comb begin
    pos    = ljust_r ? i_r : (i_r - pad);
    in_txt = ljust_r ? (i_r < txt_n) : (i_r >= pad);
    pos2   = pos - 7'(neg_r);
    didx   = 5'd0;
    if (!in_txt) begin
      cur_char = ffdf_pkg::CH_SPACE;
    end else if (neg_r && pos == 7'd0) begin
      cur_char = ffdf_pkg::CH_MINUS;
    end else if (pos2 < 7'(nd)) begin
      didx     = 5'(7'(nd) - 7'd1 - pos2);
      cur_char = ffdf_pkg::CH_ZERO + {4'd0, ibcd_r[didx*4 +: 4]};
    end else if (pos2 == 7'(nd)) begin
      cur_char = ffdf_pkg::CH_DOT;
    end else begin
      didx     = 5'(7'(p_eff) + 7'(nd) - pos2);
      cur_char = ffdf_pkg::CH_ZERO + {4'd0, fbcd_r[didx*4 +: 4]};
    end
  end

  // Sequencer outputs
  logic emit_go;
  logic emit_end;
  logic [63:0] pw;
  logic        fix_over;

  always_comb begin
    in_stall = (state_r != ffdf_pkg::ST_IDLE);
    emit_go  = (state_r == ffdf_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
    emit_end = emit_go && (i_r + 7'd1 == total);
    pw       = ffdf_pkg::pow10(p_eff);
    fix_over = (fr_r >= pw);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffdf_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!dec_frac) begin
            state_nxt = ffdf_pkg::ST_BCDI;
          end else if (p_eff != 5'd0) begin
            state_nxt = ffdf_pkg::ST_MUL;
          end else begin
            state_nxt = ffdf_pkg::ST_RND;
          end
        end
      end
      ffdf_pkg::ST_MUL: begin
        if (mcnt_r + 5'd1 == p_eff) state_nxt = ffdf_pkg::ST_RND;
      end
      ffdf_pkg::ST_RND:  state_nxt = ffdf_pkg::ST_SHF;
      ffdf_pkg::ST_SHF:  state_nxt = ffdf_pkg::ST_FIX;
      ffdf_pkg::ST_FIX:  state_nxt = ffdf_pkg::ST_BCDI;
      ffdf_pkg::ST_BCDI: begin
        if (cnt_r == 6'd63) state_nxt = ffdf_pkg::ST_BCDF;
      end
      ffdf_pkg::ST_BCDF: begin
        if (cnt_r == 6'd63) state_nxt = ffdf_pkg::ST_EMIT;
      end
      ffdf_pkg::ST_EMIT: begin
        if (emit_end) state_nxt = ffdf_pkg::ST_IDLE;
      end
      default: state_nxt = ffdf_pkg::ST_IDLE;
    endcase
  end

  // Shared BCD step unit
  logic [79:0] dd_out;
  assign dd_out = ffdf_pkg::dd_step((state_r == ffdf_pkg::ST_BCDI) ? ibcd_r : fbcd_r,
                                    (state_r == ffdf_pkg::ST_BCDI) ? ip_r[63] : fr_r[63]);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffdf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ffdf_pkg::ST_IDLE: begin
        neg_r     <= in_value_bits[63];
        ip_r      <= dec_ip;
        prod_r    <= {75'd0, dec_fm};
        k_r       <= dec_k[6:0];
        fr_r      <= 64'd0;
        ibcd_r    <= 80'd0;
        fbcd_r    <= 80'd0;
        mcnt_r    <= 5'd0;
        cnt_r     <= 6'd0;
        i_r       <= 7'd0;
      end
      ffdf_pkg::ST_MUL: begin
        prod_r <= (prod_r << 3) + (prod_r << 1);
        mcnt_r <= mcnt_r + 5'd1;
      end
      ffdf_pkg::ST_RND: begin
        prod_r <= prod_r + (128'd1 << (k_r - 7'd1));
      end
      ffdf_pkg::ST_SHF: begin
        fr_r <= 64'(prod_r >> k_r);
      end
      ffdf_pkg::ST_FIX: begin
        if (fix_over) begin
          fr_r <= fr_r - pw;
          ip_r <= ip_r + 64'd1;
        end
      end
      ffdf_pkg::ST_BCDI: begin
        ibcd_r <= dd_out;
        ip_r   <= {ip_r[62:0], 1'b0};
        cnt_r  <= cnt_r + 6'd1;
      end
      ffdf_pkg::ST_BCDF: begin
        fbcd_r <= dd_out;
        fr_r   <= {fr_r[62:0], 1'b0};
        cnt_r  <= cnt_r + 6'd1;
      end
      ffdf_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_char_r <= cur_char;
          out_last_r <= emit_end;
          i_r        <= i_r + 7'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

  // Checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ffdf_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_text_char) && $stable(out_last_char)))
    else $error("stalled beat changed");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffdf_pkg::ST_EMIT) |-> (i_r < total))
    else $error("emit index beyond text");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ffdf_pkg::ST_IDLE))
    else $error("accepted value not started");

endmodule

[sim/float_fixed_decimal_formatter_tb.sv]
// Self-checking testbench for the %f decimal formatter: random and directed values, stalls.
`timescale 1ns / 1ps
module float_fixed_decimal_formatter_tb;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } char_beat_t;

  // Byte addresses of the format registers
  localparam logic [3:0] ADDR_PREC  = {ffdf_pkg::REG_PREC, 2'b00};
  localparam logic [3:0] ADDR_WIDTH = {ffdf_pkg::REG_WIDTH, 2'b00};
  localparam logic [3:0] ADDR_LJUST = {ffdf_pkg::REG_LJUST, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_value_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_text_char;
  logic        out_last_char;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  float_fixed_decimal_formatter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_value_bits(in_value_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_text_char(out_text_char), .out_last_char(out_last_char),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the format registers
  logic [4:0] fmt_prec = 5'd6;
  logic [6:0] fmt_width = 7'd0;
  logic       fmt_ljust = 1'b0;

  logic [63:0] pending_values[$];
  char_beat_t  expected_chars[$];
  int          error_count = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [63:0] ten_pow(input int unsigned n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < n; i++) r = r * 64'd10;
    return r;
  endfunction

  // Work out the characters one value produces under the current format
  task automatic format_value(input logic [63:0] bits);
    logic        neg;
    logic [10:0] ex;
    logic [63:0] m, ip, fr, fm, pw;
    logic [127:0] prod;
    int          sh, k, n, nd, p, w, total, pad;
    logic [7:0]  txt[64];
    logic [7:0]  rev[20];
    char_beat_t  cb;
    neg = bits[63];
    ex  = bits[62:52];
    p   = (fmt_prec > ffdf_pkg::MAX_PRECISION) ? ffdf_pkg::MAX_PRECISION : fmt_prec;
    w   = (fmt_width > ffdf_pkg::MAX_WIDTH) ? ffdf_pkg::MAX_WIDTH : fmt_width;
    pw  = ten_pow(p);
    ip  = '0;
    fr  = '0;
    n   = 0;
    nd  = 0;
    if (ex == 11'h7FF) begin
      ip = ffdf_pkg::SAT_INT;
    end else begin
      m  = (ex != 0) ? {11'd0, 1'b1, bits[51:0]} : {12'd0, bits[51:0]};
      sh = (ex != 0) ? int'(ex) - 1075 : -1074;
      if (sh >= 0) begin
        ip = (sh >= 11) ? ffdf_pkg::SAT_INT : (m << sh);
      end else begin
        k  = -sh;
        fm = (k >= 64) ? m : (m & ((64'd1 << k) - 64'd1));
        ip = (k >= 64) ? 64'd0 : (m >> k);
        if (k >= 118) begin
          fr = '0;
        end else begin
          prod = {64'd0, fm} * {64'd0, pw} + (128'd1 << (k - 1));
          fr   = 64'(prod >> k);
        end
        // Carry out of the fraction goes into the integer part
        if (fr >= pw) begin
          ip = ip + 64'd1;
          fr = fr - pw;
        end
      end
    end
    if (neg) txt[n++] = ffdf_pkg::CH_MINUS;
    do begin
      rev[nd++] = 8'(48 + ip % 10);
      ip = ip / 10;
    end while (ip != 0 && nd < 20);
    while (nd > 0) txt[n++] = rev[--nd];
    if (p != 0) begin
      txt[n++] = ffdf_pkg::CH_DOT;
      for (int j = p - 1; j >= 0; j--) txt[n++] = 8'(48 + (fr / ten_pow(j)) % 10);
    end
    total = (n > w) ? n : w;
    pad   = total - n;
    for (int i = 0; i < total; i++) begin
      if (fmt_ljust) cb.text_char = (i < n) ? txt[i] : ffdf_pkg::CH_SPACE;
      else cb.text_char = (i < pad) ? ffdf_pkg::CH_SPACE : txt[i - pad];
      cb.last_char = (i + 1 == total);
      expected_chars.push_back(cb);
    end
  endtask

  // Input driver: holds each beat until accepted, idles at random
  always @(posedge clk) begin
    logic        busy;
    logic [63:0] nxt;
    busy = in_valid;
    if (in_valid && !in_stall) begin
      format_value(in_value_bits);
      busy = 1'b0;
    end
    if (!busy && rst_n) begin
      if (pending_values.size() > 0 && (no_idle || $urandom_range(0, 99) >= 24)) begin
        nxt = pending_values.pop_front();
        in_valid <= 1'b1;
        in_value_bits <= nxt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: compares each character beat, drives stall
  always @(posedge clk) begin
    int hold_cnt;
    char_beat_t exp_b;
    if (out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h", out_text_char));
      end else begin
        exp_b = expected_chars.pop_front();
        if (out_text_char !== exp_b.text_char)
          report_mismatch($sformatf("char %h, want %h", out_text_char, exp_b.text_char));
        if (out_last_char !== exp_b.last_char)
          report_mismatch($sformatf("last %b, want %b", out_last_char, exp_b.last_char));
      end
    end
    if (hold_req && hold_cnt == 0) hold_cnt = 600;
    if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_req = 1'b0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 24);
    end
  end

  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_PREC:  fmt_prec = data[4:0];
      ADDR_WIDTH: fmt_width = data[6:0];
      ADDR_LJUST: fmt_ljust = data[0];
      default: ;
    endcase
  endtask

  task automatic set_format(input int p, input int w, input int lj);
    reg_write(ADDR_PREC, p);
    reg_write(ADDR_WIDTH, w);
    reg_write(ADDR_LJUST, lj);
  endtask

  task automatic wait_drained();
    while (pending_values.size() > 0 || in_valid || expected_chars.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: v[62:52] = 11'(993 + $urandom_range(0, 100));
      2: begin  // few mantissa bits: exact halves and ties
        v[62:52] = 11'(1020 + $urandom_range(0, 12));
        v[40:0] = '0;
      end
      3: v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
      4: v[62:52] = 11'(1084 + $urandom_range(0, 3));
      default: v[62:52] = 11'($urandom_range(0, 1023));
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] directed[$];
    int settings[7][3];
    directed = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                 64'h3FF0_0000_0000_0000, 64'h3FE0_0000_0000_0000,
                 64'h4004_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0001, 64'h43E0_0000_0000_0000,
                 64'h43DF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
                 64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h405E_DD2F_1A9F_BE77, 64'hC08F_4000_0000_0000,
                 64'h3EB0_C6F7_A0B5_ED8D, 64'h4330_0000_0000_0001};
    settings = '{'{0, 0, 0}, '{19, 64, 1}, '{31, 127, 0}, '{3, 30, 0},
                 '{10, 45, 1}, '{1, 0, 1}, '{6, 12, 0}};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);
    // Directed values under the reset format, then with precision zero
    foreach (directed[i]) pending_values.push_back(directed[i]);
    wait_drained();
    reg_write(4'd12, 32'hFFFF_FFFF);
    set_format(0, 0, 0);
    foreach (directed[i]) pending_values.push_back(directed[i]);
    wait_drained();
    for (int ph = 0; ph < 7; ph++) begin
      set_format(settings[ph][0], settings[ph][1], settings[ph][2]);
      no_idle = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      repeat (20) pending_values.push_back(random_value());
      wait_drained();
    end
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(12 * 1_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
